/* rtl/e2q_pkg.sv */
// e2q_pkg: shared types and constants for the euler to quaternion datapath
// no dependencies; used by e2q_lane, e2q_merge and euler_to_quaternion_top
package e2q_pkg;

  // field widths
  localparam int ANGLE_W  = 19;
  localparam int OUT_W    = 16;
  localparam int OUT_FRAC = 15;
  localparam int QB       = 30;

  // period of the half angle in input units: 720 degrees, 8 fraction bits
  localparam int PHASE_W = 18;
  localparam logic [PHASE_W-1:0] PERIOD = 18'd184320;

  // r * 2^32 / PERIOD reduces to r * 2^20 / 45
  localparam int QDIV = 45;
  localparam int QDIV_SH = 24;
  localparam logic [18:0] QDIV_RECIP = 19'd372828;
  localparam int FRAC_W = 20;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // taylor series denominators, highest term first
  localparam int STEPS = 7;
  localparam int S_DIV [STEPS] = '{210, 156, 110, 72, 42, 20, 6};
  localparam int C_DIV [STEPS] = '{182, 132, 90, 56, 30, 12, 2};

  typedef logic signed [31:0] q30_t;

  typedef struct packed {
    q30_t sn;
    q30_t cs;
  } trig_t;

  typedef logic [FRAC_W-1:0] frac_t;
  typedef frac_t frac_tab_t [64];

  // floor(b * 2^20 / 45) for each remainder b, unused codes read zero
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t t;
    for (int i = 0; i < 64; i++) begin
      if (i < QDIV) t[i] = frac_t'((longint'(i) << FRAC_W) / QDIV);
      else t[i] = '0;
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

/* rtl/euler_to_quaternion_top.sv */
// euler_to_quaternion_top: three angle lanes and a quaternion merge stage
// depends on e2q_pkg, e2q_lane, e2q_merge
//
// channel   direction  payload (low bits first)
// s_axis    in         angle_x[18:0], angle_y[37:19], angle_z[56:38]
// m_axis    out        quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
//
// one request per cycle unless the pipeline holds; each result passes a lane, then the merge
// throughput is set by the fully pipelined lanes and merge, every stage registered
// reset clears only the valid pipeline; the datapath registers are not reset
// when the output request is not taken, the whole pipeline holds
module euler_to_quaternion_top import e2q_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // angle_x, angle_y, angle_z, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // quat_x, quat_y, quat_z, quat_w
);

  localparam int LAT = 24;

  logic en;
  logic [LAT-1:0] vld;
  trig_t tx, ty, tz;
  logic signed [OUT_W-1:0] quat_x, quat_y, quat_z, quat_w;

  // pipeline advances unless a finished result is held back
  assign en = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  // valid tracking along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // one lane per angle
  e2q_lane u_lane_x (
    .clk(clk), .en(en), .angle(signed'(s_axis_tdata[18:0])), .trig(tx)
  );
  e2q_lane u_lane_y (
    .clk(clk), .en(en), .angle(signed'(s_axis_tdata[37:19])), .trig(ty)
  );
  e2q_lane u_lane_z (
    .clk(clk), .en(en), .angle(signed'(s_axis_tdata[56:38])), .trig(tz)
  );

  // quaternion products and output scaling
  e2q_merge u_merge (
    .clk(clk), .en(en), .tx(tx), .ty(ty), .tz(tz),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
  );

  assign m_axis_tdata = {quat_w, quat_z, quat_y, quat_x};

endmodule

/* rtl/e2q_lane.sv */
// e2q_lane: sine and cosine of the negated half angle of one euler angle
// depends on e2q_pkg; 21 pipeline stages, one angle per cycle while en is high
module e2q_lane import e2q_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [ANGLE_W-1:0] angle,
  output trig_t                     trig
);

  localparam logic signed [20:0] P1 = 21'sd184320;
  localparam logic [19:0] P4_1 = 20'd184320;
  localparam logic [19:0] P4_2 = 20'd368640;
  localparam logic [19:0] P4_3 = 20'd552960;

  // stage 1: negate and wrap into one period
  logic signed [20:0] ang_neg;
  logic [PHASE_W-1:0] n_next, n_r;

  assign ang_neg = -21'(angle);

  always_comb begin
    if (ang_neg < 0) begin
      if (ang_neg + P1 < 0) n_next = PHASE_W'(ang_neg + P1 + P1);
      else n_next = PHASE_W'(ang_neg + P1);
    end else if (ang_neg >= P1) begin
      n_next = PHASE_W'(ang_neg - P1);
    end else begin
      n_next = PHASE_W'(ang_neg);
    end
  end

  // stage 2: quadrant and remainder
  logic [19:0] four_n;
  logic [1:0] q_next, q2_r;
  logic [PHASE_W-1:0] r_next, r2_r;

  assign four_n = {n_r, 2'b00};

  always_comb begin
    if (four_n >= P4_3) begin
      q_next = 2'd3; r_next = PHASE_W'(four_n - P4_3);
    end else if (four_n >= P4_2) begin
      q_next = 2'd2; r_next = PHASE_W'(four_n - P4_2);
    end else if (four_n >= P4_1) begin
      q_next = 2'd1; r_next = PHASE_W'(four_n - P4_1);
    end else begin
      q_next = 2'd0; r_next = PHASE_W'(four_n);
    end
  end

  // stage 3: quotient by 45 through the reciprocal
  logic [36:0] recip_prod;
  logic [11:0] a3_r;
  logic [PHASE_W-1:0] r3_r;
  logic [1:0] q3_r;

  assign recip_prod = 37'(r2_r) * 37'(QDIV_RECIP);

  // stage 4: quarter turn fraction and octant fold
  logic [5:0] b_rem;
  logic [31:0] u_raw, u_next, u4_r;
  logic swap_next, sw4_r;
  logic [1:0] q4_r;

  assign b_rem = 6'(r3_r - PHASE_W'(a3_r) * PHASE_W'(6'd45));
  assign u_raw = {a3_r, {FRAC_W{1'b0}}} + 32'(FRAC_TAB[b_rem]);

  always_comb begin
    if (u_raw > 32'h8000_0000) begin
      u_next = 32'(33'h1_0000_0000 - 33'(u_raw));
      swap_next = 1'b1;
    end else begin
      u_next = u_raw;
      swap_next = 1'b0;
    end
  end

  // stage 5: scale to radians; stage 6: square
  logic [62:0] rad_prod;
  logic [29:0] phi5_r, phi6_r, x2_r;
  logic [59:0] sq_prod;
  logic sw5_r, sw6_r;
  logic [1:0] q5_r, q6_r;

  assign rad_prod = 63'(u4_r) * 63'(HALF_PI_Q30);
  assign sq_prod = 60'(phi5_r) * 60'(phi5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_next;
      q2_r <= q_next;
      r2_r <= r_next;
      a3_r <= recip_prod[35:24];
      r3_r <= r2_r;
      q3_r <= q2_r;
      u4_r <= u_next;
      sw4_r <= swap_next;
      q4_r <= q3_r;
      phi5_r <= rad_prod[61:32];
      sw5_r <= sw4_r;
      q5_r <= q4_r;
      phi6_r <= phi5_r;
      x2_r <= sq_prod[59:30];
      sw6_r <= sw5_r;
      q6_r <= q5_r;
    end
  end

  // horner chain, two stages per term: product, then divide and subtract
  logic [30:0] s_st [STEPS+1];
  logic [30:0] c_st [STEPS+1];
  logic [29:0] x2_st [STEPS+1];
  logic [29:0] phi_st [STEPS+1];
  logic sw_st [STEPS+1];
  logic [1:0] q_st [STEPS+1];

  assign s_st[0] = ONE_Q30;
  assign c_st[0] = ONE_Q30;
  assign x2_st[0] = x2_r;
  assign phi_st[0] = phi6_r;
  assign sw_st[0] = sw6_r;
  assign q_st[0] = q6_r;

  for (genvar g = 0; g < STEPS; g++) begin : g_term
    localparam int DS = S_DIV[g];
    localparam int DC = C_DIV[g];
    localparam int KS = QB + $clog2(DS);
    localparam int KC = QB + $clog2(DC);
    localparam logic [31:0] MS = 32'(((64'd1 << KS) + 64'(DS) - 64'd1) / 64'(DS));
    localparam logic [31:0] MC = 32'(((64'd1 << KC) + 64'(DC) - 64'd1) / 64'(DC));

    logic [60:0] ps_a, pc_a;
    logic [29:0] ts_r, tc_r, x2_a, phi_a;
    logic sw_a;
    logic [1:0] q_a;
    logic [61:0] ds_b, dc_b;
    logic [30:0] s_r, c_r;
    logic [29:0] x2_b, phi_b;
    logic sw_b;
    logic [1:0] q_b;

    assign ps_a = 61'(x2_st[g]) * 61'(s_st[g]);
    assign pc_a = 61'(x2_st[g]) * 61'(c_st[g]);
    assign ds_b = 62'(ts_r) * 62'(MS);
    assign dc_b = 62'(tc_r) * 62'(MC);

    always_ff @(posedge clk) begin
      if (en) begin
        ts_r <= ps_a[59:30];
        tc_r <= pc_a[59:30];
        x2_a <= x2_st[g];
        phi_a <= phi_st[g];
        sw_a <= sw_st[g];
        q_a <= q_st[g];
        s_r <= ONE_Q30 - 31'(ds_b >> KS);
        c_r <= ONE_Q30 - 31'(dc_b >> KC);
        x2_b <= x2_a;
        phi_b <= phi_a;
        sw_b <= sw_a;
        q_b <= q_a;
      end
    end

    assign s_st[g+1] = s_r;
    assign c_st[g+1] = c_r;
    assign x2_st[g+1] = x2_b;
    assign phi_st[g+1] = phi_b;
    assign sw_st[g+1] = sw_b;
    assign q_st[g+1] = q_b;
  end

  // final stage: sine times phi, undo the fold, place in quadrant
  logic [60:0] sf_prod;
  q30_t s_f, c_f, s_o, c_o;
  trig_t trig_next;

  assign sf_prod = 61'(phi_st[STEPS]) * 61'(s_st[STEPS]);

  always_comb begin
    s_f = q30_t'(sf_prod[60:30]);
    c_f = q30_t'(c_st[STEPS]);
    if (sw_st[STEPS]) begin
      s_o = c_f; c_o = s_f;
    end else begin
      s_o = s_f; c_o = c_f;
    end
    case (q_st[STEPS])
      2'd0: begin trig_next.sn = s_o; trig_next.cs = c_o; end
      2'd1: begin trig_next.sn = c_o; trig_next.cs = -s_o; end
      2'd2: begin trig_next.sn = -s_o; trig_next.cs = -c_o; end
      default: begin trig_next.sn = -c_o; trig_next.cs = s_o; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) trig <= trig_next;
  end

endmodule

/* rtl/e2q_merge.sv */
// e2q_merge: combines the three lanes' sine and cosine into a quaternion
// depends on e2q_pkg; three pipeline stages
module e2q_merge import e2q_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  trig_t                   tx,
  input  trig_t                   ty,
  input  trig_t                   tz,
  output logic signed [OUT_W-1:0] quat_x,
  output logic signed [OUT_W-1:0] quat_y,
  output logic signed [OUT_W-1:0] quat_z,
  output logic signed [OUT_W-1:0] quat_w
);

  // q30 product, rounded half away from zero on magnitudes
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic [30:0] ma, mb;
    logic [61:0] p;
    logic [31:0] m;
    ma = (a < 0) ? 31'(-a) : 31'(a);
    mb = (b < 0) ? 31'(-b) : 31'(b);
    p = 62'(ma) * 62'(mb) + (62'd1 << (QB - 1));
    m = 32'(p >> QB);
    return ((a < 0) != (b < 0)) ? -q30_t'(m) : q30_t'(m);
  endfunction

  // q30 sum to q1.15, rounded half away from zero, saturated
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [32:0] m;
    logic signed [OUT_W-1:0] r;
    mag = (v < 0) ? 33'(-v) : 33'(v);
    m = (mag + (33'd1 << (QB - OUT_FRAC - 1))) >> (QB - OUT_FRAC);
    if (v < 0) begin
      if (m > 33'(1 << OUT_FRAC)) r = {1'b1, {(OUT_W-1){1'b0}}};
      else r = OUT_W'(-m);
    end else begin
      if (m > 33'((1 << OUT_FRAC) - 1)) r = {1'b0, {(OUT_W-1){1'b1}}};
      else r = OUT_W'(m);
    end
    return r;
  endfunction

  // stage 1: pair products
  q30_t sxcy_r, cxsy_r, cxcy_r, sxsy_r, sz_r, cz_r;
  // stage 2: triple products
  q30_t p_sxcycz, p_cxsysz, p_cxsycz, p_sxcysz, p_cxcysz, p_sxsycz, p_cxcycz, p_sxsysz;

  always_ff @(posedge clk) begin
    if (en) begin
      sxcy_r <= qmul(tx.sn, ty.cs);
      cxsy_r <= qmul(tx.cs, ty.sn);
      cxcy_r <= qmul(tx.cs, ty.cs);
      sxsy_r <= qmul(tx.sn, ty.sn);
      sz_r <= tz.sn;
      cz_r <= tz.cs;
      p_sxcycz <= qmul(sxcy_r, cz_r);
      p_cxsysz <= qmul(cxsy_r, sz_r);
      p_cxsycz <= qmul(cxsy_r, cz_r);
      p_sxcysz <= qmul(sxcy_r, sz_r);
      p_cxcysz <= qmul(cxcy_r, sz_r);
      p_sxsycz <= qmul(sxsy_r, cz_r);
      p_cxcycz <= qmul(cxcy_r, cz_r);
      p_sxsysz <= qmul(sxsy_r, sz_r);
      // stage 3: sums and output scaling
      quat_x <= to_out(33'(p_sxcycz) - 33'(p_cxsysz));
      quat_y <= to_out(33'(p_cxsycz) + 33'(p_sxcysz));
      quat_z <= to_out(33'(p_cxcysz) - 33'(p_sxsycz));
      quat_w <= to_out(33'(p_cxcycz) + 33'(p_sxsysz));
    end
  end

endmodule
